// File: src/rgbwd_pkg.sv
// Shared types and constants for the RGBW dimmer with linear fade.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rgbwd_pkg;

  localparam int DATA_BITS      = 16;
  localparam int PDATA_BITS     = 32;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int FADE_TIME_BITS = 20;
  localparam logic [FADE_TIME_BITS-1:0] FADE_TIME_RESET = 20'd1000;

  // Register index, taken from paddr[2].
  localparam logic REG_FADE_TIME = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_SET_CHANNEL = 2'd1,
    OP_SET_DIM     = 2'd2,
    OP_POWER       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_WAIT,
    ST_MAX,
    ST_DIM_ISSUE,
    ST_DIM_WAIT,
    ST_OUT_ISSUE,
    ST_OUT_WAIT,
    ST_SEND
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

// File: src/rgbwd_muldiv.sv
// Bit-serial unit that computes floor(a * b / d): shift-add multiply, then restoring divide.
// Depends on rgbwd_pkg. The caller guarantees that the quotient fits in A_BITS bits.
`timescale 1ns / 1ps

module rgbwd_muldiv #(
  parameter int A_BITS = 16,
  parameter int B_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [A_BITS-1:0] a,
  input  logic [B_BITS-1:0] b,
  input  logic [B_BITS-1:0] d,
  output logic              done,
  output logic [A_BITS-1:0] quot
);
  import rgbwd_pkg::*;

  localparam int P_BITS   = A_BITS + B_BITS;
  localparam int CNT_BITS = $clog2((A_BITS > B_BITS ? A_BITS : B_BITS) + 1);

  md_state_t           state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic [A_BITS-1:0]   mcand;
  logic [B_BITS-1:0]   mplier;
  logic [B_BITS-1:0]   dvsr;
  logic [B_BITS-1:0]   acc_hi;
  logic [A_BITS-1:0]   acc_lo;
  logic [P_BITS-1:0]   mul_sum;
  logic [B_BITS:0]     rem_sh;
  logic [B_BITS:0]     rem_diff;
  logic                qbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      MD_IDLE: begin
        if (start) begin
          state_next = MD_MUL;
          cnt_next   = CNT_BITS'(B_BITS - 1);
        end
      end
      MD_MUL: begin
        if (cnt == '0) begin
          state_next = MD_DIV;
          cnt_next   = CNT_BITS'(A_BITS - 1);
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      MD_DIV: begin
        if (cnt == '0) begin
          state_next = MD_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  assign mul_sum  = {acc_hi[B_BITS-2:0], acc_lo, 1'b0}
                  + P_BITS'(mplier[B_BITS-1] ? mcand : '0);
  assign rem_sh   = {acc_hi, acc_lo[A_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr};
  assign qbit     = ~rem_diff[B_BITS];

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          mcand  <= a;
          mplier <= b;
          dvsr   <= d;
          acc_hi <= '0;
          acc_lo <= '0;
        end
      end
      MD_MUL: begin
        {acc_hi, acc_lo} <= mul_sum;
        mplier           <= {mplier[B_BITS-2:0], 1'b0};
      end
      MD_DIV: begin
        acc_hi <= qbit ? rem_diff[B_BITS-1:0] : rem_sh[B_BITS-1:0];
        acc_lo <= {acc_lo[A_BITS-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

  assign done = (state == MD_DONE);
  assign quot = acc_lo;

endmodule

// File: src/rgbw_dimmer_with_fade_core.sv
// Top level of the four-channel RGBW dimmer with a linear master fade.
// Depends on rgbwd_pkg and rgbwd_muldiv.
`timescale 1ns / 1ps

// The block takes one item at a time and returns one result per item. Every
// product and quotient goes through one shared bit-serial multiply-divide unit.
// An item needs up to four passes through it to scale the channels by the
// master level, one more for a fade tick, and up to four more for a dim change;
// a zero channel skips its pass. A result waits in the output register while
// the next item is taken.
module rgbw_dimmer_with_fade_core #(
  parameter int TIMER_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rgbwd_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [rgbwd_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [rgbwd_pkg::PDATA_BITS-1:0]     prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic [1:0]                           channel,
  input  logic [rgbwd_pkg::DATA_BITS-1:0]      value,
  input  logic                                 power_on,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rgbwd_pkg::DATA_BITS-1:0]      out_red,
  output logic [rgbwd_pkg::DATA_BITS-1:0]      out_green,
  output logic [rgbwd_pkg::DATA_BITS-1:0]      out_blue,
  output logic [rgbwd_pkg::DATA_BITS-1:0]      out_white,
  output logic [rgbwd_pkg::DATA_BITS-1:0]      dim_level,
  output logic                                 power_state,
  output logic                                 fading
);
  import rgbwd_pkg::*;

  localparam int LEVEL_BITS = DATA_BITS;
  localparam int WORK_BITS = (LEVEL_BITS > TIMER_BITS) ? LEVEL_BITS : TIMER_BITS;
  localparam int FTX_BITS  = (TIMER_BITS > FADE_TIME_BITS) ? TIMER_BITS : FADE_TIME_BITS;
  localparam longint LEVEL_MAX_I = (longint'(1) << LEVEL_BITS) - 1;
  localparam longint DIM_MIN_LEVEL_I = (LEVEL_MAX_I * 5 + 50) / 100;

  typedef logic [LEVEL_BITS-1:0] lvl_t;
  typedef logic [TIMER_BITS-1:0] tmr_t;
  typedef logic [WORK_BITS-1:0]  wrk_t;
  typedef logic [FTX_BITS-1:0]   ftx_t;

  localparam lvl_t LEVEL_MAX = '1;
  localparam lvl_t DIM_MIN_LEVEL = DIM_MIN_LEVEL_I[LEVEL_BITS-1:0];
  localparam tmr_t TIMER_MAX = '1;

  ctrl_state_t               state, state_next;
  logic [FADE_TIME_BITS-1:0] fade_time;
  lvl_t                      chan [4];
  lvl_t                      res [4];
  lvl_t                      dim_value;
  lvl_t                      master_level;
  lvl_t                      fade_origin;
  logic                      fade_goal_full;
  tmr_t                      elapsed_ticks;
  logic                      powered;
  logic                      turning_off;
  lvl_t                      target;
  lvl_t                      max_q;
  logic [1:0]                idx;

  opcode_t op_in;
  logic    accept;
  logic    cfg_write;
  logic    out_free;
  lvl_t    val_l;
  lvl_t    goal;
  logic    at_goal;
  ftx_t    ft_x;
  tmr_t    ft_eff;
  tmr_t    elapsed_inc;
  logic    fade_end;
  lvl_t    max01, max23, max_chan;
  lvl_t    dim_clamp;
  lvl_t    fade_span;
  logic    chan_nz;
  logic    out_nz;

  logic md_start;
  lvl_t md_a;
  wrk_t md_b;
  wrk_t md_d;
  logic md_done;
  lvl_t md_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                  && (paddr[CFG_ADDR_BITS-1] == REG_FADE_TIME);

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_BITS-1] == REG_FADE_TIME) begin
      prdata = PDATA_BITS'(fade_time);
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op_in    = opcode_t'(opcode);
  assign val_l    = lvl_t'(value);
  assign out_free = !out_valid || !out_stall;

  assign goal    = fade_goal_full ? LEVEL_MAX : '0;
  assign at_goal = (master_level == goal);

  assign ft_x        = FTX_BITS'(fade_time);
  assign ft_eff      = (ft_x == '0) ? tmr_t'(1)
                     : (ft_x > FTX_BITS'(TIMER_MAX)) ? TIMER_MAX : tmr_t'(ft_x);
  assign elapsed_inc = (elapsed_ticks == TIMER_MAX) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign fade_end    = (elapsed_inc >= ft_eff);

  assign max01    = (chan[0] > chan[1]) ? chan[0] : chan[1];
  assign max23    = (chan[2] > chan[3]) ? chan[2] : chan[3];
  assign max_chan = (max01 > max23) ? max01 : max23;

  assign dim_clamp = (val_l < DIM_MIN_LEVEL) ? DIM_MIN_LEVEL : val_l;
  assign fade_span = fade_goal_full ? LEVEL_MAX - fade_origin : fade_origin;
  assign chan_nz   = (chan[idx] != '0);
  assign out_nz    = powered && chan_nz && (master_level != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    md_start   = 1'b0;
    md_a       = chan[idx];
    md_b       = wrk_t'(master_level);
    md_d       = wrk_t'(LEVEL_MAX);
    case (state)
      ST_IDLE: begin
        md_a = fade_span;
        md_b = wrk_t'(elapsed_inc);
        md_d = wrk_t'(ft_eff);
        if (accept) begin
          case (op_in)
            OP_TICK: begin
              if (!at_goal && !fade_end) begin
                md_start   = 1'b1;
                state_next = ST_TICK_WAIT;
              end else begin
                state_next = ST_OUT_ISSUE;
              end
            end
            OP_SET_CHANNEL: state_next = ST_MAX;
            OP_SET_DIM:     state_next = (max_chan == '0) ? ST_OUT_ISSUE : ST_DIM_ISSUE;
            OP_POWER:       state_next = ST_OUT_ISSUE;
            default:        state_next = ST_OUT_ISSUE;
          endcase
        end
      end
      ST_TICK_WAIT: begin
        if (md_done) begin
          state_next = ST_OUT_ISSUE;
        end
      end
      ST_MAX: state_next = ST_OUT_ISSUE;
      ST_DIM_ISSUE: begin
        md_b = wrk_t'(target);
        md_d = wrk_t'(max_q);
        if (chan_nz) begin
          md_start   = 1'b1;
          state_next = ST_DIM_WAIT;
        end else if (idx == 2'd3) begin
          state_next = ST_OUT_ISSUE;
        end
      end
      ST_DIM_WAIT: begin
        if (md_done) begin
          state_next = (idx == 2'd3) ? ST_OUT_ISSUE : ST_DIM_ISSUE;
        end
      end
      ST_OUT_ISSUE: begin
        if (out_nz) begin
          md_start   = 1'b1;
          state_next = ST_OUT_WAIT;
        end else if (idx == 2'd3) begin
          state_next = ST_SEND;
        end
      end
      ST_OUT_WAIT: begin
        if (md_done) begin
          state_next = (idx == 2'd3) ? ST_SEND : ST_OUT_ISSUE;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_time      <= FADE_TIME_RESET;
      for (int i = 0; i < 4; i++) begin
        chan[i] <= '0;
      end
      dim_value      <= '0;
      master_level   <= '0;
      fade_origin    <= '0;
      fade_goal_full <= 1'b0;
      elapsed_ticks  <= '0;
      powered        <= 1'b0;
      turning_off    <= 1'b0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        fade_time <= pwdata[FADE_TIME_BITS-1:0];
      end
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            case (op_in)
              OP_TICK: begin
                elapsed_ticks <= elapsed_inc;
                if (!at_goal && fade_end) begin
                  master_level <= goal;
                  if (turning_off) begin
                    powered     <= 1'b0;
                    turning_off <= 1'b0;
                  end
                end
              end
              OP_SET_CHANNEL: chan[channel] <= val_l;
              OP_SET_DIM: begin
                dim_value <= dim_clamp;
              end
              OP_POWER: begin
                fade_origin    <= master_level;
                fade_goal_full <= power_on;
                elapsed_ticks  <= '0;
                if (power_on) begin
                  powered     <= 1'b1;
                  turning_off <= 1'b0;
                end else begin
                  turning_off <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_TICK_WAIT: begin
          if (md_done) begin
            master_level <= fade_goal_full ? fade_origin + md_q : fade_origin - md_q;
          end
        end
        ST_MAX: dim_value <= max_chan;
        ST_DIM_ISSUE: begin
          if (!chan_nz) begin
            idx <= idx + 1'b1;
          end
        end
        ST_DIM_WAIT: begin
          if (md_done) begin
            chan[idx] <= md_q;
            idx       <= idx + 1'b1;
          end
        end
        ST_OUT_ISSUE: begin
          if (!out_nz) begin
            idx <= idx + 1'b1;
          end
        end
        ST_OUT_WAIT: begin
          if (md_done) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (state == ST_SEND && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      target <= dim_clamp;
      max_q  <= max_chan;
    end
    if (state == ST_OUT_ISSUE && !out_nz) begin
      res[idx] <= '0;
    end
    if (state == ST_OUT_WAIT && md_done) begin
      res[idx] <= md_q;
    end
    if (state == ST_SEND && out_free) begin
      out_red     <= DATA_BITS'(res[0]);
      out_green   <= DATA_BITS'(res[1]);
      out_blue    <= DATA_BITS'(res[2]);
      out_white   <= DATA_BITS'(res[3]);
      dim_level   <= DATA_BITS'(dim_value);
      power_state <= powered;
      fading      <= !at_goal;
    end
  end

  rgbwd_muldiv #(
    .A_BITS(LEVEL_BITS),
    .B_BITS(WORK_BITS)
  ) u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .start(md_start),
    .a    (md_a),
    .b    (md_b),
    .d    (md_d),
    .done (md_done),
    .quot (md_q)
  );

endmodule

// File: src/rgbwd_checker.sv
// Port-level checks for the RGBW dimmer core, bound to the top level.
// Depends on rgbwd_pkg and rgbw_dimmer_with_fade_core.
`timescale 1ns / 1ps

module rgbwd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [rgbwd_pkg::CFG_ADDR_BITS-1:0] paddr,
  input logic [rgbwd_pkg::PDATA_BITS-1:0]    pwdata,
  input logic [rgbwd_pkg::PDATA_BITS-1:0]    prdata,
  input logic                                pready,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [1:0]                          opcode,
  input logic [1:0]                          channel,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     value,
  input logic                                power_on,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     out_red,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     out_green,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     out_blue,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     out_white,
  input logic [rgbwd_pkg::DATA_BITS-1:0]     dim_level,
  input logic                                power_state,
  input logic                                fading
);
  import rgbwd_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_white) && $stable(dim_level)
      && $stable(power_state) && $stable(fading))
    else $error("stalled result changed");

  // The core works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  // All drive levels are zero while the light is off.
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !power_state |-> out_red == '0 && out_green == '0
      && out_blue == '0 && out_white == '0)
    else $error("nonzero drive while powered off");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("pready low during access");

endmodule

bind rgbw_dimmer_with_fade_core rgbwd_checker u_checker (.*);

// File: tb/tb_rgbw_dimmer_with_fade_core.sv
// Self-checking testbench for the RGBW dimmer with linear master fade.
// Drives items and fade-time writes, predicts each result with its own model.
// Depends on rgbwd_pkg and rgbw_dimmer_with_fade_core.
`timescale 1ns / 1ps

module tb_rgbw_dimmer_with_fade_core;
  import rgbwd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 112;
  localparam int NUM_PHASES = 10;
  localparam logic [DATA_BITS-1:0] FULL_SCALE = '1;
  localparam logic [DATA_BITS-1:0] DIM_MIN = 16'd3277;

  typedef struct packed {
    logic [DATA_BITS-1:0] red;
    logic [DATA_BITS-1:0] green;
    logic [DATA_BITS-1:0] blue;
    logic [DATA_BITS-1:0] white;
    logic [DATA_BITS-1:0] dim;
    logic                 pwr;
    logic                 fade;
  } level_set_t;

  class dimmer_scoreboard;
    logic [DATA_BITS-1:0] chan_lvl [4];
    logic [DATA_BITS-1:0] dim_q;
    logic [DATA_BITS-1:0] master;
    logic [DATA_BITS-1:0] origin;
    logic goal_full;
    logic powered;
    logic turning_off;
    logic [FADE_TIME_BITS-1:0] elapsed;
    logic [FADE_TIME_BITS-1:0] fade_time;
    level_set_t drive_levels_q[$];
    int errors;
    int checked;
    int fades_done;

    function new();
      foreach (chan_lvl[i]) chan_lvl[i] = '0;
      dim_q = '0;
      master = '0;
      origin = '0;
      goal_full = 1'b0;
      powered = 1'b0;
      turning_off = 1'b0;
      elapsed = '0;
      fade_time = FADE_TIME_RESET;
      errors = 0;
      checked = 0;
      fades_done = 0;
    endfunction

    function void load_fade_time(logic [FADE_TIME_BITS-1:0] ft);
      fade_time = ft;
    endfunction

    function logic [DATA_BITS-1:0] peak();
      logic [DATA_BITS-1:0] m;
      m = '0;
      foreach (chan_lvl[i]) if (chan_lvl[i] > m) m = chan_lvl[i];
      return m;
    endfunction

    function void step_fade();
      longint unsigned ft, o, e;
      logic [DATA_BITS-1:0] goal;
      ft = (fade_time == '0) ? 1 : fade_time;
      goal = goal_full ? FULL_SCALE : '0;
      if (elapsed != '1) elapsed++;
      if (master == goal) return;
      o = origin;
      e = elapsed;
      if (e >= ft) begin
        master = goal;
        if (turning_off) begin
          powered = 1'b0;
          turning_off = 1'b0;
          fades_done++;
        end
      end else if (goal_full) begin
        master = DATA_BITS'(o + ((longint'(FULL_SCALE) - o) * e) / ft);
      end else begin
        master = DATA_BITS'(o - (o * e) / ft);
      end
    endfunction

    function void rescale_to_dim(logic [DATA_BITS-1:0] val);
      longint unsigned tgt, m, s;
      tgt = (val < DIM_MIN) ? DIM_MIN : val;
      m = peak();
      if (m != 0) begin
        foreach (chan_lvl[i]) begin
          if (chan_lvl[i] != '0) begin
            s = (longint'(chan_lvl[i]) * tgt) / m;
            chan_lvl[i] = (s > FULL_SCALE) ? FULL_SCALE : DATA_BITS'(s);
          end
        end
      end
      dim_q = DATA_BITS'(tgt);
    endfunction

    function void note_item(opcode_t op, logic [1:0] ch, logic [DATA_BITS-1:0] val, logic on);
      level_set_t want;
      longint unsigned m;
      case (op)
        OP_TICK: step_fade();
        OP_SET_CHANNEL: begin
          chan_lvl[ch] = val;
          dim_q = peak();
        end
        OP_SET_DIM: rescale_to_dim(val);
        OP_POWER: begin
          origin = master;
          goal_full = on;
          elapsed = '0;
          if (on) begin
            powered = 1'b1;
            turning_off = 1'b0;
          end else begin
            turning_off = 1'b1;
          end
        end
        default: begin
        end
      endcase
      m = master;
      want.red = powered ? DATA_BITS'((chan_lvl[0] * m) / FULL_SCALE) : '0;
      want.green = powered ? DATA_BITS'((chan_lvl[1] * m) / FULL_SCALE) : '0;
      want.blue = powered ? DATA_BITS'((chan_lvl[2] * m) / FULL_SCALE) : '0;
      want.white = powered ? DATA_BITS'((chan_lvl[3] * m) / FULL_SCALE) : '0;
      want.dim = dim_q;
      want.pwr = powered;
      want.fade = (master != (goal_full ? FULL_SCALE : '0));
      drive_levels_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(level_set_t got);
      level_set_t want;
      if (drive_levels_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none, got %p", $time, got);
        return;
      end
      want = drive_levels_q.pop_front();
      checked++;
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_white", want.white, got.white);
      compare_field("dim_level", want.dim, got.dim);
      compare_field("power_state", want.pwr, got.pwr);
      compare_field("fading", want.fade, got.fade);
    endfunction

    function int pending();
      return drive_levels_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  opcode_t opcode = OP_TICK;
  logic [1:0] channel = '0;
  logic [DATA_BITS-1:0] value = '0;
  logic power_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_BITS-1:0] out_red, out_green, out_blue, out_white, dim_level;
  logic power_state, fading;

  dimmer_scoreboard sb = new();
  int items_sent = 0;
  int settings_done = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int stall_left = 0;
  int rx_calm_left = 0;
  int tx_calm_left = 0;

  rgbw_dimmer_with_fade_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .value(value), .power_on(power_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_white(out_white), .dim_level(dim_level),
    .power_state(power_state), .fading(fading)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    logic nxt;
    int r;
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(level_set_t'({out_red, out_green, out_blue, out_white,
                                    dim_level, power_state, fading}));
    end
    nxt = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      stall_left = HOLD_CYCLES - 1;
      nxt = 1'b1;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        rx_calm_left = $urandom_range(20, 200);
      end else if (r < 25) begin
        stall_left = $urandom_range(0, 3);
        nxt = 1'b1;
      end else if (r < 28) begin
        stall_left = $urandom_range(30, 150);
        nxt = 1'b1;
      end
    end
    out_stall <= nxt;
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      tx_calm_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return FULL_SCALE;
    if (r < 30) return DATA_BITS'($urandom_range(1, 16));
    if (r < 40) return DATA_BITS'($urandom_range(3270, 3284));
    return DATA_BITS'($urandom);
  endfunction

  task automatic send_cmd(opcode_t op, logic [1:0] ch, logic [DATA_BITS-1:0] val, logic on);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    channel <= ch;
    value <= val;
    power_on <= on;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, ch, val, on);
    items_sent++;
  endtask

  task automatic send_tick();
    send_cmd(OP_TICK, 2'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic send_channel(logic [1:0] ch, logic [DATA_BITS-1:0] val);
    send_cmd(OP_SET_CHANNEL, ch, val, 1'($urandom));
  endtask

  task automatic send_dim(logic [DATA_BITS-1:0] val);
    send_cmd(OP_SET_DIM, 2'($urandom), val, 1'($urandom));
  endtask

  task automatic send_power(logic on);
    send_cmd(OP_POWER, 2'($urandom), 16'($urandom), on);
  endtask

  task automatic write_fade_time(logic [FADE_TIME_BITS-1:0] ft);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FADE_TIME, 2'b00};
    pwdata <= {12'($urandom), ft};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.load_fade_time(ft);
    settings_done++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_burst(int ft_eff);
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_power(1'($urandom));
      n = $urandom_range(0, (ft_eff + 2 > 40) ? 40 : ft_eff + 2);
      repeat (n) send_tick();
    end else if (r < 50) begin
      repeat ($urandom_range(1, 8)) send_tick();
    end else if (r < 72) begin
      send_channel(2'($urandom), pick_level());
    end else if (r < 88) begin
      send_dim(pick_level());
    end else begin
      send_cmd(opcode_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: %0d cycles with no item accepted on either side", WATCHDOG_LIMIT);
    $display("tb_rgbw_dimmer_with_fade_core: done, errors");
    $finish;
  end

  initial begin
    logic [FADE_TIME_BITS-1:0] phase_ft [NUM_PHASES];
    int start, ft_eff;
    phase_ft = '{20'd2, 20'd1, 20'd7, 20'd40, 20'd1000, 20'd600000, 20'd0,
                 20'hFFFFF, 20'd13, 20'd0};
    phase_ft[NUM_PHASES-1] = FADE_TIME_BITS'($urandom_range(1, 600000));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_tick();
    send_dim(16'd0);
    send_power(1'b1);
    send_channel(2'd0, FULL_SCALE);
    send_tick();
    send_tick();
    write_fade_time(20'd3);
    send_channel(2'd1, 16'h8000);
    send_channel(2'd2, 16'd1);
    send_channel(2'd3, 16'd0);
    send_dim(16'd0);
    send_dim(FULL_SCALE);
    send_dim(16'd3276);
    send_dim(DIM_MIN);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_power(1'b0);
    send_tick();
    send_power(1'b1);
    send_tick();
    send_power(1'b0);
    repeat (3) send_tick();
    send_power(1'b1);
    send_power(1'b0);
    send_tick();
    send_channel(2'd3, FULL_SCALE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_fade_time(phase_ft[p]);
      if (p == 3) hold_requests++;
      ft_eff = (phase_ft[p] == '0) ? 1 : int'(phase_ft[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_burst(ft_eff);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("summary: %0d items sent, %0d results checked under %0d fade-time writes,",
             items_sent, sb.checked, settings_done);
    $display("summary: %0d fades to off ran to completion", sb.fades_done);
    if (sb.errors == 0) begin
      $display("tb_rgbw_dimmer_with_fade_core: done, clean");
    end else begin
      $display("tb_rgbw_dimmer_with_fade_core: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rgbwd_pkg.sv
src/rgbwd_muldiv.sv
src/rgbw_dimmer_with_fade_core.sv
src/rgbwd_checker.sv
tb/tb_rgbw_dimmer_with_fade_core.sv
